// ===== hdl/fwks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwks_pkg
// Operation and status codes and shared types for the searchable queue.
// ----------------------------------------------------------------------------
package fwks_pkg;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_REWIND = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_FIND   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int KEY_W = 32;
    localparam int PAY_W = 64;
    localparam int LKEY_W = 31;

    typedef struct packed {
        logic clr;
        logic vld;
    } scan_ctl_t;

endpackage

// ===== hdl/fwks_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwks_store
// Key and payload slot memories, one write port, registered read ports.
// ----------------------------------------------------------------------------
module fwks_store #(
    parameter int DEPTH = 16,
    parameter int SW    = 4
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [SW-1:0]                   wr_slot,
    input  logic [fwks_pkg::KEY_W-1:0]      wr_key,
    input  logic [fwks_pkg::PAY_W-1:0]      wr_payload,
    input  logic [SW-1:0]                   krd_slot,
    input  logic [SW-1:0]                   prd_slot,
    output logic [fwks_pkg::KEY_W-1:0]      krd_data,
    output logic [fwks_pkg::PAY_W-1:0]      prd_data
);

    logic [fwks_pkg::KEY_W-1:0] key_mem [DEPTH];
    logic [fwks_pkg::PAY_W-1:0] pay_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_slot] <= wr_key;
            pay_mem[wr_slot] <= wr_payload;
        end
    end

    always_ff @(posedge aclk) begin
        krd_data <= key_mem[krd_slot];
        prd_data <= pay_mem[prd_slot];
    end

endmodule

// ===== hdl/fwks_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwks_scan
// Shared compare unit: running largest key and key match over the walk.
// ----------------------------------------------------------------------------
module fwks_scan (
    input  logic                             aclk,
    input  fwks_pkg::scan_ctl_t              ctl,
    input  logic signed [fwks_pkg::KEY_W-1:0] key,
    input  logic [fwks_pkg::KEY_W-1:0]       find_key,
    output logic [fwks_pkg::LKEY_W-1:0]      largest,
    output logic                             found
);

    logic [fwks_pkg::LKEY_W-1:0] best_reg;
    logic                        found_reg;
    logic                        greater;

    assign greater = key > $signed({1'b0, best_reg});

    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            best_reg  <= '0;
            found_reg <= 1'b0;
        end else if (ctl.vld) begin
            if (greater) begin
                best_reg <= key[fwks_pkg::LKEY_W-1:0];
            end
            if (key == find_key) begin
                found_reg <= 1'b1;
            end
        end
    end

    assign largest = best_reg;
    assign found   = found_reg;

endmodule

// ===== hdl/fifo_with_key_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_key_search
// Ring queue of (key, payload) entries with read cursor, key search and a
// running largest key, computed by walking the held entries each item.
//
// channel  dir  handshake          fields
// s_       in   s_valid/s_ready    s_operation, s_key, s_payload
// m_       out  m_valid/m_ready    m_status, m_out_key, m_out_payload,
//                                  m_found, m_entries, m_largest_key
//
// Each item steps through the access, walk, drain and finish states; the walk
// covers the entries held after the operation, and the next item is taken
// only once the result has been registered. The walk reads one slot per cycle
// through the key memory read port.
// s_ready is high only in the idle state; the finished result sits in the
// output register while the next item is taken.
// aresetn empties the queue and resets the cursor; slot memories are not
// cleared. A stalled m_ side holds the finished item before the next one.
// ----------------------------------------------------------------------------
module fifo_with_key_search #(
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_operation,
    input  logic signed [fwks_pkg::KEY_W-1:0]     s_key,
    input  logic [fwks_pkg::PAY_W-1:0]            s_payload,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_status,
    output logic signed [fwks_pkg::KEY_W-1:0]     m_out_key,
    output logic [fwks_pkg::PAY_W-1:0]            m_out_payload,
    output logic                                  m_found,
    output logic [$clog2(DEPTH+1)-1:0]            m_entries,
    output logic [fwks_pkg::LKEY_W-1:0]           m_largest_key
);

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SUMW = SW + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ACCESS = 5'b00010,
        S_WALK   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [CW-1:0] held_reg, held_next;
    logic [CW-1:0] coff_reg, coff_next;
    logic          cend_reg, cend_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] wslot_reg, wslot_next;
    logic          walk_v_reg, walk_v_next;
    logic          access_d_reg, access_d_next;
    logic          take_reg, take_next;
    logic [1:0]    status_reg, status_next;
    logic          m_valid_reg, m_valid_next;

    logic [2:0]                  op_reg;
    logic [fwks_pkg::KEY_W-1:0]  key_reg;
    logic [fwks_pkg::PAY_W-1:0]  pay_reg;
    logic [fwks_pkg::KEY_W-1:0]  rkey_reg;
    logic [fwks_pkg::PAY_W-1:0]  rpay_reg;

    logic [1:0]                  m_status_reg;
    logic [fwks_pkg::KEY_W-1:0]  m_key_reg;
    logic [fwks_pkg::PAY_W-1:0]  m_pay_reg;
    logic                        m_found_reg;
    logic [CW-1:0]               m_entries_reg;
    logic [fwks_pkg::LKEY_W-1:0] m_largest_reg;

    logic                        wr_en;
    logic [SUMW-1:0]             csum;
    logic [SW-1:0]               cslot;
    logic [SW-1:0]               rd_slot;
    logic [SW-1:0]               krd_slot;
    logic [fwks_pkg::KEY_W-1:0]  krd_data;
    logic [fwks_pkg::PAY_W-1:0]  prd_data;
    fwks_pkg::scan_ctl_t         scan_ctl;
    logic [fwks_pkg::LKEY_W-1:0] scan_largest;
    logic                        scan_found;
    logic                        out_free;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    assign csum  = {1'b0, head_reg} + SUMW'(coff_reg);
    assign cslot = (csum >= SUMW'(DEPTH)) ? SW'(csum - SUMW'(DEPTH)) : csum[SW-1:0];
    assign rd_slot  = (op_reg == fwks_pkg::OP_POP) ? head_reg : cslot;
    assign krd_slot = (state_reg == S_ACCESS) ? rd_slot : wslot_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        held_next     = held_reg;
        coff_next     = coff_reg;
        cend_next     = cend_reg;
        idx_next      = idx_reg;
        wslot_next    = wslot_reg;
        walk_v_next   = 1'b0;
        access_d_next = 1'b0;
        take_next     = take_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;
        scan_ctl      = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS: begin
                scan_ctl.clr  = 1'b1;
                access_d_next = 1'b1;
                take_next     = 1'b0;
                status_next   = fwks_pkg::ST_DONE;
                case (op_reg)
                    fwks_pkg::OP_PUSH: begin
                        if (held_reg == CW'(DEPTH)) begin
                            status_next = fwks_pkg::ST_FULL;
                        end else begin
                            wr_en     = 1'b1;
                            tail_next = slot_inc(tail_reg);
                            held_next = held_reg + 1'b1;
                        end
                    end
                    fwks_pkg::OP_POP: begin
                        if (held_reg == '0) begin
                            status_next = fwks_pkg::ST_EMPTY;
                        end else begin
                            take_next = 1'b1;
                            head_next = slot_inc(head_reg);
                            held_next = held_reg - 1'b1;
                            if (coff_reg != '0) begin
                                coff_next = coff_reg - 1'b1;
                            end
                        end
                    end
                    fwks_pkg::OP_REWIND: begin
                        coff_next = '0;
                        cend_next = (held_reg == '0);
                    end
                    fwks_pkg::OP_READ: begin
                        if (cend_reg || coff_reg >= held_reg) begin
                            status_next = fwks_pkg::ST_EMPTY;
                        end else begin
                            take_next = 1'b1;
                            coff_next = coff_reg + 1'b1;
                            if (coff_reg + 1'b1 == held_reg) begin
                                cend_next = 1'b1;
                            end
                        end
                    end
                    fwks_pkg::OP_CLEAR: begin
                        head_next = '0;
                        tail_next = '0;
                        held_next = '0;
                        coff_next = '0;
                        cend_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
                idx_next   = '0;
                wslot_next = head_next;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (idx_reg == held_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    walk_v_next = 1'b1;
                    idx_next    = idx_reg + 1'b1;
                    wslot_next  = slot_inc(wslot_reg);
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        scan_ctl.vld = walk_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            held_reg     <= '0;
            coff_reg     <= '0;
            cend_reg     <= 1'b0;
            idx_reg      <= '0;
            wslot_reg    <= '0;
            walk_v_reg   <= 1'b0;
            access_d_reg <= 1'b0;
            take_reg     <= 1'b0;
            status_reg   <= fwks_pkg::ST_DONE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            held_reg     <= held_next;
            coff_reg     <= coff_next;
            cend_reg     <= cend_next;
            idx_reg      <= idx_next;
            wslot_reg    <= wslot_next;
            walk_v_reg   <= walk_v_next;
            access_d_reg <= access_d_next;
            take_reg     <= take_next;
            status_reg   <= status_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_operation;
            key_reg <= s_key;
            pay_reg <= s_payload;
        end
        if (access_d_reg) begin
            rkey_reg <= take_reg ? krd_data : '0;
            rpay_reg <= take_reg ? prd_data : '0;
        end
        if (state_reg == S_FINISH && out_free) begin
            m_status_reg  <= status_reg;
            m_key_reg     <= rkey_reg;
            m_pay_reg     <= rpay_reg;
            m_found_reg   <= (op_reg == fwks_pkg::OP_FIND) && scan_found;
            m_entries_reg <= held_reg;
            m_largest_reg <= scan_largest;
        end
    end

    fwks_store #(
        .DEPTH(DEPTH),
        .SW   (SW)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_slot   (tail_reg),
        .wr_key    (key_reg),
        .wr_payload(pay_reg),
        .krd_slot  (krd_slot),
        .prd_slot  (rd_slot),
        .krd_data  (krd_data),
        .prd_data  (prd_data)
    );

    fwks_scan u_scan (
        .aclk    (aclk),
        .ctl     (scan_ctl),
        .key     (krd_data),
        .find_key(key_reg),
        .largest (scan_largest),
        .found   (scan_found)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_key     = m_key_reg;
    assign m_out_payload = m_pay_reg;
    assign m_found       = m_found_reg;
    assign m_entries     = m_entries_reg;
    assign m_largest_key = m_largest_reg;

endmodule

// ===== hdl/fwks_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwks_checker
// Port-level checks for the searchable queue, bound to the top level.
// ----------------------------------------------------------------------------
module fwks_checker #(
    parameter int DEPTH = 16
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [1:0]                        m_status,
    input logic [fwks_pkg::KEY_W-1:0]        m_out_key,
    input logic [fwks_pkg::PAY_W-1:0]        m_out_payload,
    input logic [$clog2(DEPTH+1)-1:0]        m_entries
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entries)
            && $stable(m_out_key) && $stable(m_out_payload))
        else $error("stalled result item changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entries <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == fwks_pkg::ST_FULL |-> m_entries == ($clog2(DEPTH+1))'(DEPTH))
        else $error("push dropped while not full");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != fwks_pkg::ST_DONE |-> m_out_key == '0 && m_out_payload == '0)
        else $error("failed item carries entry data");

endmodule

bind fifo_with_key_search fwks_checker #(
    .DEPTH(DEPTH)
) u_fwks_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_out_key    (m_out_key),
    .m_out_payload(m_out_payload),
    .m_entries    (m_entries)
);
